@@ src/pis_pkg.sv @@
// ----------------------------------------------------------------------------
// pis_pkg: shared types and constants of the projectile intercept solver
// field widths, internal datapath widths and the beat side structs that
// travel next to the square root and division pipelines
// ----------------------------------------------------------------------------
package pis_pkg;

  // field widths
  localparam int COORD_W  = 24;
  localparam int RAD_W    = 16;
  localparam int SPEED_W  = 24;
  localparam int LIFE_W   = 24;
  localparam int TIME_W   = 24;
  localparam int AIM_W    = 32;
  localparam int IN_W     = 6 * COORD_W + RAD_W;
  localparam int OUT_W    = TIME_W + 3 * AIM_W;

  // configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED    = 2'd0,
    REG_RADIUS   = 2'd1,
    REG_LIFETIME = 2'd2
  } cfg_reg_t;

  // coefficient datapath
  localparam int PROD_W = 2 * COORD_W;     // one coordinate product
  localparam int COEF_W = 51;              // a, b, c signed
  localparam int MAG_W  = 50;              // |a|, |b|, |c|
  localparam int HALF_W = MAG_W / 2;       // split for partial products
  localparam int PART_W = 2 * HALF_W;      // one partial product
  localparam int MID_W  = PART_W + 1;      // sum of cross products

  // square root
  localparam int SQ_RAD_W  = 2 * MAG_W;    // radicand
  localparam int SQ_ROOT_W = SQ_RAD_W / 2;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;
  localparam int SQ_STEPS  = SQ_ROOT_W;

  // root, lifetime check and division
  localparam int TIME_FRAC = 16;
  localparam int NUM_W     = 53;
  localparam int DEN_W     = 52;
  localparam int NMAG_W    = NUM_W - 1;
  localparam int DMAG_W    = DEN_W - 1;
  localparam int NUMW_W    = NMAG_W + TIME_FRAC;
  localparam int LT_W      = LIFE_W + DMAG_W;
  localparam int DL_W      = 26;           // low part of |den| for life product
  localparam int DV_Q_W    = TIME_W;

  // aim
  localparam int PV_W = COORD_W + TIME_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec_t;

  // beat side data through the square root
  typedef struct packed {
    vec_t                     d;
    vec_t                     v;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic                     ok;
  } sq_side_t;

  // beat side data through the divider
  typedef struct packed {
    vec_t d;
    vec_t v;
    logic ok;
  } dv_side_t;

endpackage

@@ src/pis_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// pis_sqrt_pipe: pipelined integer square root
// one root bit per register stage, floor of the exact root of the radicand
// ----------------------------------------------------------------------------
module pis_sqrt_pipe (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [pis_pkg::SQ_RAD_W-1:0]     in_rad,
  input  pis_pkg::sq_side_t                in_side,
  output logic                             out_vld,
  output logic [pis_pkg::SQ_ROOT_W-1:0]    out_root,
  output pis_pkg::sq_side_t                out_side
);

  logic [pis_pkg::SQ_STEPS-1:0]    v_r;
  logic [pis_pkg::SQ_STEPS-1:0]    v_nxt;
  logic [pis_pkg::SQ_RAD_W-1:0]    rad_r    [pis_pkg::SQ_STEPS];
  logic [pis_pkg::SQ_RAD_W-1:0]    rad_nxt  [pis_pkg::SQ_STEPS];
  logic [pis_pkg::SQ_REM_W-1:0]    rem_r    [pis_pkg::SQ_STEPS];
  logic [pis_pkg::SQ_REM_W-1:0]    rem_nxt  [pis_pkg::SQ_STEPS];
  logic [pis_pkg::SQ_ROOT_W-1:0]   root_r   [pis_pkg::SQ_STEPS];
  logic [pis_pkg::SQ_ROOT_W-1:0]   root_nxt [pis_pkg::SQ_STEPS];
  pis_pkg::sq_side_t               side_r   [pis_pkg::SQ_STEPS];
  pis_pkg::sq_side_t               side_nxt [pis_pkg::SQ_STEPS];

  // one trial subtraction per stage
  always_comb begin
    logic [pis_pkg::SQ_RAD_W-1:0]  rin;
    logic [pis_pkg::SQ_REM_W-1:0]  remin;
    logic [pis_pkg::SQ_ROOT_W-1:0] rootin;
    logic [pis_pkg::SQ_REM_W+1:0]  rem_cat;
    logic [pis_pkg::SQ_REM_W+2:0]  trial;
    for (int k = 0; k < pis_pkg::SQ_STEPS; k++) begin
      if (k == 0) begin
        v_nxt[k]    = in_vld;
        rin         = in_rad;
        remin       = '0;
        rootin      = '0;
        side_nxt[k] = in_side;
      end else begin
        v_nxt[k]    = v_r[k-1];
        rin         = rad_r[k-1];
        remin       = rem_r[k-1];
        rootin      = root_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      rem_cat = {remin, rin[pis_pkg::SQ_RAD_W-1 -: 2]};
      trial   = {1'b0, rem_cat} - (pis_pkg::SQ_REM_W+3)'({rootin, 2'b01});
      rad_nxt[k] = rin << 2;
      if (!trial[pis_pkg::SQ_REM_W+2]) begin
        rem_nxt[k] = trial[pis_pkg::SQ_REM_W-1:0];
      end else begin
        rem_nxt[k] = rem_cat[pis_pkg::SQ_REM_W-1:0];
      end
      root_nxt[k] = {rootin[pis_pkg::SQ_ROOT_W-2:0], !trial[pis_pkg::SQ_REM_W+2]};
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_vld  = v_r[pis_pkg::SQ_STEPS-1];
  assign out_root = root_r[pis_pkg::SQ_STEPS-1];
  assign out_side = side_r[pis_pkg::SQ_STEPS-1];

endmodule

@@ src/pis_div_pipe.sv @@
// ----------------------------------------------------------------------------
// pis_div_pipe: pipelined restoring divider
// one quotient bit per register stage, quotient is the floor of num / den
// ----------------------------------------------------------------------------
module pis_div_pipe (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [pis_pkg::NUMW_W-1:0]     in_num,
  input  logic [pis_pkg::DMAG_W-1:0]     in_den,
  input  pis_pkg::dv_side_t              in_side,
  output logic                           out_vld,
  output logic [pis_pkg::DV_Q_W-1:0]     out_q,
  output pis_pkg::dv_side_t              out_side
);

  logic [pis_pkg::DV_Q_W-1:0]  v_r;
  logic [pis_pkg::DV_Q_W-1:0]  v_nxt;
  logic [pis_pkg::NUMW_W-1:0]  rem_r    [pis_pkg::DV_Q_W];
  logic [pis_pkg::NUMW_W-1:0]  rem_nxt  [pis_pkg::DV_Q_W];
  logic [pis_pkg::DMAG_W-1:0]  den_r    [pis_pkg::DV_Q_W];
  logic [pis_pkg::DMAG_W-1:0]  den_nxt  [pis_pkg::DV_Q_W];
  logic [pis_pkg::DV_Q_W-1:0]  q_r      [pis_pkg::DV_Q_W];
  logic [pis_pkg::DV_Q_W-1:0]  q_nxt    [pis_pkg::DV_Q_W];
  pis_pkg::dv_side_t           side_r   [pis_pkg::DV_Q_W];
  pis_pkg::dv_side_t           side_nxt [pis_pkg::DV_Q_W];

  // compare and subtract the shifted divisor, msb first
  always_comb begin
    logic [pis_pkg::NUMW_W-1:0] rin;
    logic [pis_pkg::DMAG_W-1:0] din;
    logic [pis_pkg::DV_Q_W-1:0] qin;
    logic [pis_pkg::LT_W-1:0]   sh;
    logic                       fits;
    for (int k = 0; k < pis_pkg::DV_Q_W; k++) begin
      if (k == 0) begin
        v_nxt[k]    = in_vld;
        rin         = in_num;
        din         = in_den;
        qin         = '0;
        side_nxt[k] = in_side;
      end else begin
        v_nxt[k]    = v_r[k-1];
        rin         = rem_r[k-1];
        din         = den_r[k-1];
        qin         = q_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      sh   = pis_pkg::LT_W'(din) << (pis_pkg::DV_Q_W - 1 - k);
      fits = (sh <= pis_pkg::LT_W'(rin));
      rem_nxt[k] = fits ? (rin - sh[pis_pkg::NUMW_W-1:0]) : rin;
      den_nxt[k] = din;
      q_nxt[k]   = qin;
      q_nxt[k][pis_pkg::DV_Q_W-1-k] = fits;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= den_nxt;
      q_r    <= q_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_vld  = v_r[pis_pkg::DV_Q_W-1];
  assign out_q    = q_r[pis_pkg::DV_Q_W-1];
  assign out_side = side_r[pis_pkg::DV_Q_W-1];

endmodule

@@ src/projectile_intercept_solver.sv @@
// ----------------------------------------------------------------------------
// projectile_intercept_solver: intercept time and aim vector for one target
// Takes one target query per cycle and returns one result beat per query:
// 7 stages build a, b, c and the discriminant, 50 stages take the square
// root one bit each, 5 stages form the root and check it against the
// lifetime, 24 stages divide one time bit each, then one stage multiplies
// the aim and one output register holds the result. The whole pipeline
// advances together; while a result waits on the output the pipeline holds
// and in_tready is low.
// ----------------------------------------------------------------------------
module projectile_intercept_solver (
  input  logic                              clk,
  input  logic                              rst_n,
  // offset_x, offset_y, offset_z, rel_vel_x, rel_vel_y, rel_vel_z,
  // target_radius
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pis_pkg::IN_W-1:0]          in_tdata,
  // time_to_hit, aim_x, aim_y, aim_z
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pis_pkg::OUT_W-1:0]         out_tdata,
  // hit
  output logic [0:0]                        out_tuser,
  input  logic                              cfg_we,
  input  logic [pis_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [pis_pkg::CFG_W-1:0]         cfg_wdata
);

  // floor shift of v*t and saturating add to the offset
  function automatic logic signed [pis_pkg::AIM_W-1:0] aim_axis(
    input logic signed [pis_pkg::COORD_W-1:0] d,
    input logic signed [pis_pkg::PV_W-1:0]    pv
  );
    logic signed [pis_pkg::PV_W-pis_pkg::TIME_FRAC-1:0] q;
    logic signed [pis_pkg::AIM_W+1:0]                   s;
    logic signed [pis_pkg::AIM_W-1:0]                   r;
    q = signed'(pv[pis_pkg::PV_W-1:pis_pkg::TIME_FRAC]);
    s = (pis_pkg::AIM_W+2)'(d) + (pis_pkg::AIM_W+2)'(q);
    if (s[pis_pkg::AIM_W+1] && !(&s[pis_pkg::AIM_W:pis_pkg::AIM_W-1])) begin
      r = {1'b1, {(pis_pkg::AIM_W-1){1'b0}}};
    end else if (!s[pis_pkg::AIM_W+1] && (|s[pis_pkg::AIM_W:pis_pkg::AIM_W-1])) begin
      r = {1'b0, {(pis_pkg::AIM_W-1){1'b1}}};
    end else begin
      r = s[pis_pkg::AIM_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [pis_pkg::SPEED_W-1:0] speed_r;
  logic [pis_pkg::RAD_W-1:0]   radius_r;
  logic [pis_pkg::LIFE_W-1:0]  life_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r  <= '0;
      radius_r <= '0;
      life_r   <= '0;
    end else if (cfg_we) begin
      case (pis_pkg::cfg_reg_t'(cfg_addr))
        pis_pkg::REG_SPEED:    speed_r  <= cfg_wdata[pis_pkg::SPEED_W-1:0];
        pis_pkg::REG_RADIUS:   radius_r <= cfg_wdata[pis_pkg::RAD_W-1:0];
        pis_pkg::REG_LIFETIME: life_r   <= cfg_wdata[pis_pkg::LIFE_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the output register is empty or being taken
  logic out_tvalid_r;
  logic en;
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // input beat unpack
  pis_pkg::vec_t             in_d;
  pis_pkg::vec_t             in_v;
  logic [pis_pkg::RAD_W:0]   in_rsum;
  always_comb begin
    in_d.x  = in_tdata[23:0];
    in_d.y  = in_tdata[47:24];
    in_d.z  = in_tdata[71:48];
    in_v.x  = in_tdata[95:72];
    in_v.y  = in_tdata[119:96];
    in_v.z  = in_tdata[143:120];
    in_rsum = {1'b0, radius_r} + {1'b0, in_tdata[159:144]};
  end

  // stage 1: coordinate products
  logic                              s1_vld_r;
  pis_pkg::vec_t                     s1_d_r, s1_vel_r;
  logic signed [pis_pkg::PROD_W-1:0] s1_pdd_r [3];
  logic signed [pis_pkg::PROD_W-1:0] s1_pdv_r [3];
  logic signed [pis_pkg::PROD_W-1:0] s1_pvv_r [3];
  logic [2*pis_pkg::SPEED_W-1:0]     s1_ss_r;
  logic [2*pis_pkg::RAD_W+1:0]       s1_rr_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r      <= in_d;
      s1_vel_r    <= in_v;
      s1_pdd_r[0] <= pis_pkg::PROD_W'(in_d.x) * pis_pkg::PROD_W'(in_d.x);
      s1_pdd_r[1] <= pis_pkg::PROD_W'(in_d.y) * pis_pkg::PROD_W'(in_d.y);
      s1_pdd_r[2] <= pis_pkg::PROD_W'(in_d.z) * pis_pkg::PROD_W'(in_d.z);
      s1_pdv_r[0] <= pis_pkg::PROD_W'(in_d.x) * pis_pkg::PROD_W'(in_v.x);
      s1_pdv_r[1] <= pis_pkg::PROD_W'(in_d.y) * pis_pkg::PROD_W'(in_v.y);
      s1_pdv_r[2] <= pis_pkg::PROD_W'(in_d.z) * pis_pkg::PROD_W'(in_v.z);
      s1_pvv_r[0] <= pis_pkg::PROD_W'(in_v.x) * pis_pkg::PROD_W'(in_v.x);
      s1_pvv_r[1] <= pis_pkg::PROD_W'(in_v.y) * pis_pkg::PROD_W'(in_v.y);
      s1_pvv_r[2] <= pis_pkg::PROD_W'(in_v.z) * pis_pkg::PROD_W'(in_v.z);
      s1_ss_r     <= (2*pis_pkg::SPEED_W)'(speed_r) * (2*pis_pkg::SPEED_W)'(speed_r);
      s1_rr_r     <= (2*pis_pkg::RAD_W+2)'(in_rsum) * (2*pis_pkg::RAD_W+2)'(in_rsum);
    end
  end

  // stage 2: quadratic coefficients
  logic                              s2_vld_r;
  pis_pkg::vec_t                     s2_d_r, s2_vel_r;
  logic signed [pis_pkg::COEF_W-1:0] s2_a_r, s2_b_r, s2_c_r;
  logic signed [pis_pkg::COEF_W-1:0] s2_dv;

  assign s2_dv = pis_pkg::COEF_W'(s1_pdv_r[0]) + pis_pkg::COEF_W'(s1_pdv_r[1])
               + pis_pkg::COEF_W'(s1_pdv_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d_r   <= s1_d_r;
      s2_vel_r <= s1_vel_r;
      s2_a_r   <= pis_pkg::COEF_W'(s1_pvv_r[0]) + pis_pkg::COEF_W'(s1_pvv_r[1])
                + pis_pkg::COEF_W'(s1_pvv_r[2]) - pis_pkg::COEF_W'(s1_ss_r);
      s2_b_r   <= {s2_dv[pis_pkg::COEF_W-2:0], 1'b0};
      s2_c_r   <= pis_pkg::COEF_W'(s1_pdd_r[0]) + pis_pkg::COEF_W'(s1_pdd_r[1])
                + pis_pkg::COEF_W'(s1_pdd_r[2]) - pis_pkg::COEF_W'(s1_rr_r);
    end
  end

  // stage 3: magnitudes and sign of 4ac
  logic                       s3_vld_r;
  pis_pkg::sq_side_t          s3_side_r;
  logic [pis_pkg::MAG_W-1:0]  s3_am_r, s3_bm_r, s3_cm_r;
  logic                       s3_sub_r;
  logic [pis_pkg::COEF_W-1:0] s3_an, s3_bn, s3_cn;

  assign s3_an = s2_a_r[pis_pkg::COEF_W-1] ? -s2_a_r : s2_a_r;
  assign s3_bn = s2_b_r[pis_pkg::COEF_W-1] ? -s2_b_r : s2_b_r;
  assign s3_cn = s2_c_r[pis_pkg::COEF_W-1] ? -s2_c_r : s2_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r.d  <= s2_d_r;
      s3_side_r.v  <= s2_vel_r;
      s3_side_r.a  <= s2_a_r;
      s3_side_r.b  <= s2_b_r;
      s3_side_r.ok <= (s2_a_r != '0);
      s3_am_r      <= s3_an[pis_pkg::MAG_W-1:0];
      s3_bm_r      <= s3_bn[pis_pkg::MAG_W-1:0];
      s3_cm_r      <= s3_cn[pis_pkg::MAG_W-1:0];
      s3_sub_r     <= (s2_a_r[pis_pkg::COEF_W-1] == s2_c_r[pis_pkg::COEF_W-1]);
    end
  end

  // stage 4: partial products of b*b and a*c
  logic                       s4_vld_r;
  pis_pkg::sq_side_t          s4_side_r;
  logic                       s4_sub_r;
  logic [pis_pkg::PART_W-1:0] s4_bll_r, s4_blh_r, s4_bhh_r;
  logic [pis_pkg::PART_W-1:0] s4_fll_r, s4_flh_r, s4_fhl_r, s4_fhh_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= s3_side_r;
      s4_sub_r  <= s3_sub_r;
      s4_bll_r  <= pis_pkg::PART_W'(s3_bm_r[pis_pkg::HALF_W-1:0])
                 * pis_pkg::PART_W'(s3_bm_r[pis_pkg::HALF_W-1:0]);
      s4_blh_r  <= pis_pkg::PART_W'(s3_bm_r[pis_pkg::HALF_W-1:0])
                 * pis_pkg::PART_W'(s3_bm_r[pis_pkg::MAG_W-1:pis_pkg::HALF_W]);
      s4_bhh_r  <= pis_pkg::PART_W'(s3_bm_r[pis_pkg::MAG_W-1:pis_pkg::HALF_W])
                 * pis_pkg::PART_W'(s3_bm_r[pis_pkg::MAG_W-1:pis_pkg::HALF_W]);
      s4_fll_r  <= pis_pkg::PART_W'(s3_am_r[pis_pkg::HALF_W-1:0])
                 * pis_pkg::PART_W'(s3_cm_r[pis_pkg::HALF_W-1:0]);
      s4_flh_r  <= pis_pkg::PART_W'(s3_am_r[pis_pkg::HALF_W-1:0])
                 * pis_pkg::PART_W'(s3_cm_r[pis_pkg::MAG_W-1:pis_pkg::HALF_W]);
      s4_fhl_r  <= pis_pkg::PART_W'(s3_am_r[pis_pkg::MAG_W-1:pis_pkg::HALF_W])
                 * pis_pkg::PART_W'(s3_cm_r[pis_pkg::HALF_W-1:0]);
      s4_fhh_r  <= pis_pkg::PART_W'(s3_am_r[pis_pkg::MAG_W-1:pis_pkg::HALF_W])
                 * pis_pkg::PART_W'(s3_cm_r[pis_pkg::MAG_W-1:pis_pkg::HALF_W]);
    end
  end

  // stage 5: cross terms
  logic                       s5_vld_r;
  pis_pkg::sq_side_t          s5_side_r;
  logic                       s5_sub_r;
  logic [pis_pkg::PART_W-1:0] s5_bll_r, s5_bhh_r, s5_fll_r, s5_fhh_r;
  logic [pis_pkg::MID_W-1:0]  s5_bmid_r, s5_fmid_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side_r <= s4_side_r;
      s5_sub_r  <= s4_sub_r;
      s5_bll_r  <= s4_bll_r;
      s5_bhh_r  <= s4_bhh_r;
      s5_fll_r  <= s4_fll_r;
      s5_fhh_r  <= s4_fhh_r;
      s5_bmid_r <= {s4_blh_r, 1'b0};
      s5_fmid_r <= pis_pkg::MID_W'(s4_flh_r) + pis_pkg::MID_W'(s4_fhl_r);
    end
  end

  // stage 6: full products b*b and a*c
  logic                         s6_vld_r;
  pis_pkg::sq_side_t            s6_side_r;
  logic                         s6_sub_r;
  logic [pis_pkg::SQ_RAD_W-1:0] s6_bb_r, s6_ac_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_side_r <= s5_side_r;
      s6_sub_r  <= s5_sub_r;
      s6_bb_r   <= {s5_bhh_r, s5_bll_r}
                 + (pis_pkg::SQ_RAD_W'(s5_bmid_r) << pis_pkg::HALF_W);
      s6_ac_r   <= {s5_fhh_r, s5_fll_r}
                 + (pis_pkg::SQ_RAD_W'(s5_fmid_r) << pis_pkg::HALF_W);
    end
  end

  // stage 7: discriminant b*b - 4ac
  logic                         s7_vld_r;
  pis_pkg::sq_side_t            s7_side_r;
  pis_pkg::sq_side_t            s7_side_nxt;
  logic [pis_pkg::SQ_RAD_W-1:0] s7_rad_r;
  logic [pis_pkg::SQ_RAD_W-1:0] s6_fac;

  assign s6_fac = {s6_ac_r[pis_pkg::SQ_RAD_W-3:0], 2'b00};

  // negative discriminant is a miss
  always_comb begin
    s7_side_nxt = s6_side_r;
    if (s6_sub_r) begin
      s7_side_nxt.ok = s6_side_r.ok && (s6_fac <= s6_bb_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_side_r <= s7_side_nxt;
      if (s6_sub_r) begin
        s7_rad_r <= s6_bb_r - s6_fac;
      end else begin
        s7_rad_r <= s6_bb_r + s6_fac;
      end
    end
  end

  // square root of the discriminant
  logic                          sq_vld;
  logic [pis_pkg::SQ_ROOT_W-1:0] sq_root;
  pis_pkg::sq_side_t             sq_side;

  pis_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s7_vld_r),
    .in_rad   (s7_rad_r),
    .in_side  (s7_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // t1: root numerator and denominator, sign check
  logic                             t1_vld_r;
  pis_pkg::dv_side_t                t1_side_r;
  logic signed [pis_pkg::NUM_W-1:0] t1_num_r;
  logic signed [pis_pkg::DEN_W-1:0] t1_den_r;
  logic signed [pis_pkg::NUM_W-1:0] t1_num;
  logic signed [pis_pkg::DEN_W-1:0] t1_den;

  assign t1_num = -pis_pkg::NUM_W'(sq_side.b) - pis_pkg::NUM_W'(sq_root);
  assign t1_den = {pis_pkg::DEN_W'(sq_side.a)} <<< 1;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_side_r.d  <= sq_side.d;
      t1_side_r.v  <= sq_side.v;
      t1_side_r.ok <= sq_side.ok && !((t1_num != '0) &&
                      (t1_num[pis_pkg::NUM_W-1] != t1_den[pis_pkg::DEN_W-1]));
      t1_num_r     <= t1_num;
      t1_den_r     <= t1_den;
    end
  end

  // t2: magnitudes of numerator and denominator
  logic                       t2_vld_r;
  pis_pkg::dv_side_t          t2_side_r;
  logic [pis_pkg::NMAG_W-1:0] t2_nmag_r;
  logic [pis_pkg::DMAG_W-1:0] t2_dmag_r;
  logic [pis_pkg::NUM_W-1:0]  t2_nn;
  logic [pis_pkg::DEN_W-1:0]  t2_dn;

  assign t2_nn = t1_num_r[pis_pkg::NUM_W-1] ? -t1_num_r : t1_num_r;
  assign t2_dn = t1_den_r[pis_pkg::DEN_W-1] ? -t1_den_r : t1_den_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t2_side_r <= t1_side_r;
      t2_nmag_r <= t2_nn[pis_pkg::NMAG_W-1:0];
      t2_dmag_r <= t2_dn[pis_pkg::DMAG_W-1:0];
    end
  end

  // t3: lifetime times denominator, partial products
  localparam int LP_LO_W = pis_pkg::LIFE_W + pis_pkg::DL_W;
  localparam int LP_HI_W = pis_pkg::LIFE_W + pis_pkg::DMAG_W - pis_pkg::DL_W;

  logic                       t3_vld_r;
  pis_pkg::dv_side_t          t3_side_r;
  logic [pis_pkg::NUMW_W-1:0] t3_numw_r;
  logic [pis_pkg::DMAG_W-1:0] t3_dmag_r;
  logic [LP_LO_W-1:0]         t3_plo_r;
  logic [LP_HI_W-1:0]         t3_phi_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t3_side_r <= t2_side_r;
      t3_numw_r <= {t2_nmag_r, {pis_pkg::TIME_FRAC{1'b0}}};
      t3_dmag_r <= t2_dmag_r;
      t3_plo_r  <= LP_LO_W'(life_r) * LP_LO_W'(t2_dmag_r[pis_pkg::DL_W-1:0]);
      t3_phi_r  <= LP_HI_W'(life_r)
                 * LP_HI_W'(t2_dmag_r[pis_pkg::DMAG_W-1:pis_pkg::DL_W]);
    end
  end

  // t4: lifetime times denominator, sum
  logic                       t4_vld_r;
  pis_pkg::dv_side_t          t4_side_r;
  logic [pis_pkg::NUMW_W-1:0] t4_numw_r;
  logic [pis_pkg::DMAG_W-1:0] t4_dmag_r;
  logic [pis_pkg::LT_W-1:0]   t4_lt_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t4_side_r <= t3_side_r;
      t4_numw_r <= t3_numw_r;
      t4_dmag_r <= t3_dmag_r;
      t4_lt_r   <= (pis_pkg::LT_W'(t3_phi_r) << pis_pkg::DL_W) + pis_pkg::LT_W'(t3_plo_r);
    end
  end

  // t5: root within lifetime
  logic                       t5_vld_r;
  pis_pkg::dv_side_t          t5_side_r;
  pis_pkg::dv_side_t          t5_side_nxt;
  logic [pis_pkg::NUMW_W-1:0] t5_numw_r;
  logic [pis_pkg::DMAG_W-1:0] t5_dmag_r;

  always_comb begin
    t5_side_nxt    = t4_side_r;
    t5_side_nxt.ok = t4_side_r.ok && (pis_pkg::LT_W'(t4_numw_r) <= t4_lt_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t5_side_r <= t5_side_nxt;
      t5_numw_r <= t4_numw_r;
      t5_dmag_r <= t4_dmag_r;
    end
  end

  // time = floor(65536 * num / den)
  logic                        dv_vld;
  logic [pis_pkg::DV_Q_W-1:0]  dv_q;
  pis_pkg::dv_side_t           dv_side;

  pis_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (t5_vld_r),
    .in_num   (t5_numw_r),
    .in_den   (t5_dmag_r),
    .in_side  (t5_side_r),
    .out_vld  (dv_vld),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  // a1: velocity times time
  logic                            a1_vld_r;
  pis_pkg::dv_side_t               a1_side_r;
  logic [pis_pkg::TIME_W-1:0]      a1_t_r;
  logic signed [pis_pkg::PV_W-1:0] a1_pv_r [3];
  logic signed [pis_pkg::PV_W-1:0] a1_t;

  assign a1_t = signed'(pis_pkg::PV_W'(dv_q));

  always_ff @(posedge clk) begin
    if (en) begin
      a1_side_r  <= dv_side;
      a1_t_r     <= dv_q;
      a1_pv_r[0] <= pis_pkg::PV_W'(dv_side.v.x) * a1_t;
      a1_pv_r[1] <= pis_pkg::PV_W'(dv_side.v.y) * a1_t;
      a1_pv_r[2] <= pis_pkg::PV_W'(dv_side.v.z) * a1_t;
    end
  end

  // output register: aim add and saturate, zeros on a miss
  logic                             out_hit_r;
  logic [pis_pkg::TIME_W-1:0]       out_time_r;
  logic signed [pis_pkg::AIM_W-1:0] out_aim_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= a1_side_r.ok;
      if (a1_side_r.ok) begin
        out_time_r   <= a1_t_r;
        out_aim_r[0] <= aim_axis(a1_side_r.d.x, a1_pv_r[0]);
        out_aim_r[1] <= aim_axis(a1_side_r.d.y, a1_pv_r[1]);
        out_aim_r[2] <= aim_axis(a1_side_r.d.z, a1_pv_r[2]);
      end else begin
        out_time_r   <= '0;
        out_aim_r[0] <= '0;
        out_aim_r[1] <= '0;
        out_aim_r[2] <= '0;
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      s3_vld_r     <= 1'b0;
      s4_vld_r     <= 1'b0;
      s5_vld_r     <= 1'b0;
      s6_vld_r     <= 1'b0;
      s7_vld_r     <= 1'b0;
      t1_vld_r     <= 1'b0;
      t2_vld_r     <= 1'b0;
      t3_vld_r     <= 1'b0;
      t4_vld_r     <= 1'b0;
      t5_vld_r     <= 1'b0;
      a1_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      s1_vld_r     <= in_tvalid;
      s2_vld_r     <= s1_vld_r;
      s3_vld_r     <= s2_vld_r;
      s4_vld_r     <= s3_vld_r;
      s5_vld_r     <= s4_vld_r;
      s6_vld_r     <= s5_vld_r;
      s7_vld_r     <= s6_vld_r;
      t1_vld_r     <= sq_vld;
      t2_vld_r     <= t1_vld_r;
      t3_vld_r     <= t2_vld_r;
      t4_vld_r     <= t3_vld_r;
      t5_vld_r     <= t4_vld_r;
      a1_vld_r     <= dv_vld;
      out_tvalid_r <= a1_vld_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tuser[0] = out_hit_r;
  assign out_tdata    = {out_aim_r[2], out_aim_r[1], out_aim_r[0], out_time_r};

  // a miss carries all-zero data
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_hit_r |-> out_tdata == '0)
    else $error("miss beat with nonzero data");

  // a held output freezes the pipeline
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s1_vld_r) && $stable(t1_vld_r) && $stable(a1_vld_r))
    else $error("pipeline moved during output stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid_r && !s1_vld_r && !a1_vld_r)
    else $error("pipeline not empty after reset");

endmodule
